### rtl/ogr_pkg.sv
// ogr_pkg: shared types and constants for the occupancy grid ray update block
// used by ogr_front, ogr_queue, ogr_back and the top level; depends on nothing
package ogr_pkg;

  localparam int POS_W      = 32;
  localparam int ANG_W      = 16;
  localparam int DIST_W     = 32;
  localparam int CS_W       = 21;
  localparam int RANGE_W    = 25;
  localparam int IDX_W      = 7;
  localparam int CNT_W      = 16;
  localparam int LVL_W      = 4;
  localparam int TRIG_W     = 17;
  localparam int STEP_W     = 39;
  localparam int HOFF_W     = 28;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int MA_W       = 27;
  localparam int MB_W       = 18;
  localparam int MP_W       = MA_W + MB_W;

  localparam logic [CS_W-1:0]    CS_RESET    = 21'd6554;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 25'd327680;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 4'd10;
  localparam logic [LVL_W-1:0] HIT_STEP  = 4'd4;
  localparam logic [LVL_W-1:0] OCC_LIMIT = 4'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_RANGE = 8'd1;

  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // one classified item handed from front to back
  typedef struct packed {
    logic               mode;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [CS_W-1:0]    cell_size;
    logic [RANGE_W-1:0] limit;
    logic               hit;
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
    logic [HOFF_W-1:0]  hoff_x;
    logic [HOFF_W-1:0]  hoff_y;
    logic [IDX_W-1:0]   cell_row;
    logic [IDX_W-1:0]   cell_col;
  } desc_t;

  // queue status seen by its two sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_RD_WAIT,
    B_SAMPLE,
    B_CHECK,
    B_DIV,
    B_RMW_RD,
    B_RMW_WR,
    B_NEXT,
    B_DONE
  } back_state_t;

endpackage

### rtl/occupancy_grid_ray_update.sv
// occupancy_grid_ray_update: top level, config registers and front/queue/back
// depends on ogr_pkg, ogr_front, ogr_queue, ogr_back
//
// Keeps a GRID_SIDE x GRID_SIDE grid of 4-bit occupancy levels. After reset
// the grid memory is swept to zero, during which the input stalls; config
// writes are taken at any time. A scan item goes through the front on the
// shared multiplier (trig polynomial, step and hit products), then the back
// walks ceil(limit/cell_size) samples plus the hit sample when there is one;
// each sample goes through the bit-serial cell index divider, plus a memory
// read-modify-write when it lands in the grid. A two-entry queue lets the
// front accept the next item while the back is walking, and a result waits in
// an output register until transfer.
module occupancy_grid_ray_update #(
  parameter int GRID_SIDE = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [ogr_pkg::POS_W-1:0]      in_pos_x,
  input  logic [ogr_pkg::POS_W-1:0]      in_pos_y,
  input  logic [ogr_pkg::ANG_W-1:0]      in_heading,
  input  logic [ogr_pkg::ANG_W-1:0]      in_bearing,
  input  logic [ogr_pkg::DIST_W-1:0]     in_range_reading,
  input  logic [ogr_pkg::IDX_W-1:0]      in_cell_row,
  input  logic [ogr_pkg::IDX_W-1:0]      in_cell_col,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ogr_pkg::CNT_W-1:0]      out_cells_touched,
  output logic [ogr_pkg::LVL_W-1:0]      out_cell_level,
  output logic                           out_occupied,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ogr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [ogr_pkg::CS_W-1:0]    cell_size_r;
  logic [ogr_pkg::RANGE_W-1:0] sensor_range_r;

  logic             clear_busy, q_push, q_pop;
  ogr_pkg::desc_t   push_data, pop_data;
  ogr_pkg::q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r    <= ogr_pkg::CS_RESET;
      sensor_range_r <= ogr_pkg::RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ogr_pkg::CFG_CELL_SIZE:    cell_size_r    <= cfg_data[ogr_pkg::CS_W-1:0];
        ogr_pkg::CFG_SENSOR_RANGE: sensor_range_r <= cfg_data[ogr_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  ogr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_heading       (in_heading),
    .in_bearing       (in_bearing),
    .in_range_reading (in_range_reading),
    .in_cell_row      (in_cell_row),
    .in_cell_col      (in_cell_col),
    .cell_size        (cell_size_r),
    .sensor_range     (sensor_range_r),
    .clear_busy       (clear_busy),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_data           (push_data)
  );

  ogr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  ogr_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .q_data            (pop_data),
    .clear_busy        (clear_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cells_touched (out_cells_touched),
    .out_cell_level    (out_cell_level),
    .out_occupied      (out_occupied)
  );

endmodule

### rtl/ogr_front.sv
// ogr_front: accepts items, works out ray trig, step products and hit offsets
// on one shared multiplier, and pushes a descriptor; uses ogr_pkg
module ogr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [ogr_pkg::POS_W-1:0]    in_pos_x,
  input  logic [ogr_pkg::POS_W-1:0]    in_pos_y,
  input  logic [ogr_pkg::ANG_W-1:0]    in_heading,
  input  logic [ogr_pkg::ANG_W-1:0]    in_bearing,
  input  logic [ogr_pkg::DIST_W-1:0]   in_range_reading,
  input  logic [ogr_pkg::IDX_W-1:0]    in_cell_row,
  input  logic [ogr_pkg::IDX_W-1:0]    in_cell_col,
  input  logic [ogr_pkg::CS_W-1:0]     cell_size,
  input  logic [ogr_pkg::RANGE_W-1:0]  sensor_range,
  input  logic                         clear_busy,
  input  ogr_pkg::q_stat_t             q_stat,
  output logic                         q_push,
  output ogr_pkg::desc_t               q_data
);

  localparam logic [3:0] LAST_STEP = 4'd11;

  ogr_pkg::front_state_t state_r, state_nxt;

  logic                        mode_r;
  logic [ogr_pkg::POS_W-1:0]   px_r, py_r;
  logic [ogr_pkg::ANG_W-1:0]   ang_r;
  logic [ogr_pkg::CS_W-1:0]    cs_r;
  logic [ogr_pkg::RANGE_W-1:0] limit_r;
  logic                        hit_r;
  logic [ogr_pkg::IDX_W-1:0]   row_r, col_r;
  logic [3:0]                  step_r;
  logic [15:0]                 t_r, u_r;
  logic [16:0]                 w_r;
  logic [ogr_pkg::TRIG_W-1:0]  sv_r, cv_r;
  logic [ogr_pkg::STEP_W-1:0]  stx_r, sty_r;
  logic [ogr_pkg::HOFF_W-1:0]  hox_r, hoy_r;

  logic                        accept;
  logic [ogr_pkg::ANG_W-1:0]   ang_sel;
  logic [14:0]                 xq, arg;
  logic [15:0]                 t_c;
  logic [16:0]                 s17, sc;
  logic [ogr_pkg::TRIG_W-1:0]  trig_v;
  logic signed [ogr_pkg::MA_W-1:0] ma;
  logic signed [ogr_pkg::MB_W-1:0] mb;
  logic signed [ogr_pkg::MP_W-1:0] mp;
  logic                        hit_c;

  assign in_stall = (state_r != ogr_pkg::F_IDLE) || clear_busy;
  assign accept   = in_valid && !in_stall;
  assign hit_c    = (in_range_reading != '0) &&
                    (in_range_reading <= ogr_pkg::DIST_W'(sensor_range));

  // quarter-wave argument; cos runs on angle plus a quarter turn
  always_comb begin
    ang_sel = (step_r < 4'd4) ? ang_r : ang_r + 16'd16384;
    xq      = {1'b0, ang_sel[13:0]};
    arg     = ang_sel[14] ? 15'd16384 - xq : xq;
    t_c     = {arg, 1'b0};
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (step_r < 4'd8) begin
      case (step_r[1:0])
        2'd0: begin
          ma = $signed({11'b0, t_c});
          mb = $signed({2'b0, t_c});
        end
        2'd1: begin
          ma = 27'sd2320;
          mb = $signed({2'b0, u_r});
        end
        2'd2: begin
          ma = $signed({10'b0, 17'd21024 - w_r});
          mb = $signed({2'b0, u_r});
        end
        default: begin
          ma = $signed({10'b0, w_r});
          mb = $signed({2'b0, t_r});
        end
      endcase
    end else begin
      case (step_r)
        4'd8: begin
          ma = $signed({6'b0, cs_r});
          mb = $signed({cv_r[16], cv_r});
        end
        4'd9: begin
          ma = $signed({6'b0, cs_r});
          mb = $signed({sv_r[16], sv_r});
        end
        4'd10: begin
          ma = $signed({2'b0, limit_r});
          mb = $signed({cv_r[16], cv_r});
        end
        default: begin
          ma = $signed({2'b0, limit_r});
          mb = $signed({sv_r[16], sv_r});
        end
      endcase
    end
    mp = ma * mb;
  end

  always_comb begin
    s17    = mp[31:15];
    sc     = (s17 > 17'd32767) ? 17'd32767 : s17;
    trig_v = ang_sel[15] ? 17'd0 - sc : sc;
  end

  always_comb begin
    state_nxt = state_r;
    q_push    = 1'b0;
    case (state_r)
      ogr_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode == ogr_pkg::MODE_READ) ? ogr_pkg::F_PUSH : ogr_pkg::F_CALC;
        end
      end
      ogr_pkg::F_CALC: begin
        if (step_r == LAST_STEP) state_nxt = ogr_pkg::F_PUSH;
      end
      ogr_pkg::F_PUSH: begin
        if (!q_stat.full) begin
          q_push    = 1'b1;
          state_nxt = ogr_pkg::F_IDLE;
        end
      end
      default: state_nxt = ogr_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ogr_pkg::F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) step_r <= '0;
      else if (state_r == ogr_pkg::F_CALC) step_r <= step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      ang_r   <= in_heading + in_bearing;
      cs_r    <= (cell_size == '0) ? ogr_pkg::CS_W'(1) : cell_size;
      hit_r   <= hit_c;
      limit_r <= hit_c ? in_range_reading[ogr_pkg::RANGE_W-1:0] : sensor_range;
      row_r   <= in_cell_row;
      col_r   <= in_cell_col;
    end
    if (state_r == ogr_pkg::F_CALC) begin
      if (step_r < 4'd8) begin
        case (step_r[1:0])
          2'd0: begin
            u_r <= mp[30:15];
            t_r <= t_c;
          end
          2'd1: w_r <= mp[31:15];
          2'd2: w_r <= 17'd51472 - mp[31:15];
          default: begin
            if (step_r[2]) cv_r <= trig_v;
            else sv_r <= trig_v;
          end
        endcase
      end else begin
        case (step_r)
          4'd8:    stx_r <= mp[ogr_pkg::STEP_W-1:0];
          4'd9:    sty_r <= mp[ogr_pkg::STEP_W-1:0];
          4'd10:   hox_r <= mp[ogr_pkg::HOFF_W+14:15];
          default: hoy_r <= mp[ogr_pkg::HOFF_W+14:15];
        endcase
      end
    end
  end

  always_comb begin
    q_data.mode      = mode_r;
    q_data.pos_x     = px_r;
    q_data.pos_y     = py_r;
    q_data.cell_size = cs_r;
    q_data.limit     = limit_r;
    q_data.hit       = hit_r;
    q_data.step_x    = stx_r;
    q_data.step_y    = sty_r;
    q_data.hoff_x    = hox_r;
    q_data.hoff_y    = hoy_r;
    q_data.cell_row  = row_r;
    q_data.cell_col  = col_r;
  end

endmodule

### rtl/ogr_queue.sv
// ogr_queue: two-entry descriptor queue between front and back
// uses ogr_pkg for the descriptor and status types
module ogr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ogr_pkg::desc_t   push_data,
  input  logic             pop,
  output ogr_pkg::desc_t   pop_data,
  output ogr_pkg::q_stat_t stat
);

  ogr_pkg::desc_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

### rtl/ogr_back.sv
// ogr_back: walks the ray over the grid memory, one read-modify-write per
// in-grid sample, with a bit-serial cell index divider; uses ogr_pkg
module ogr_back #(
  parameter int GRID_SIDE = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ogr_pkg::q_stat_t            q_stat,
  output logic                        q_pop,
  input  ogr_pkg::desc_t              q_data,
  output logic                        clear_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ogr_pkg::CNT_W-1:0]   out_cells_touched,
  output logic [ogr_pkg::LVL_W-1:0]   out_cell_level,
  output logic                        out_occupied
);

  localparam int QB    = $clog2(GRID_SIDE);
  localparam int AW    = 2 * QB;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(QB);
  localparam int NUMW  = 40;
  localparam int ACC_W = 44;
  localparam int R_W   = 27;

  ogr_pkg::back_state_t state_r, state_nxt;

  ogr_pkg::desc_t          cur_r, cur_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [NUMW-1:0]         half_r, half_nxt, gcs_r, gcs_nxt;
  logic [R_W-1:0]          r_r, r_nxt;
  logic [ACC_W-1:0]        acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic                    hit_ph_r, hit_ph_nxt;
  logic [NUMW-1:0]         num_x_r, num_x_nxt, num_y_r, num_y_nxt;
  logic [NUMW-1:0]         rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt, dv_r, dv_nxt;
  logic [QB-1:0]           qx_r, qx_nxt, qy_r, qy_nxt;
  logic                    inx_r, inx_nxt, iny_r, iny_nxt;
  logic [CW-1:0]           bit_r, bit_nxt;
  logic [ogr_pkg::CNT_W-1:0] touched_r, touched_nxt;
  logic                    rd_ok_r, rd_ok_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ogr_pkg::CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [ogr_pkg::LVL_W-1:0] out_lvl_r, out_lvl_nxt;
  logic                    out_occ_r, out_occ_nxt;

  logic [ogr_pkg::LVL_W-1:0] mem [DEPTH];
  logic [ogr_pkg::LVL_W-1:0] rdata_r;
  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [ogr_pkg::LVL_W-1:0] wr_data;

  logic [NUMW-1:0]         cs_ext, sx, sy;
  logic                    ge_x, ge_y;
  logic [ogr_pkg::LVL_W:0] raised;

  assign clear_busy        = (state_r == ogr_pkg::B_CLEAR);
  assign out_valid         = out_valid_r;
  assign out_cells_touched = out_cnt_r;
  assign out_cell_level    = out_lvl_r;
  assign out_occupied      = out_occ_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_comb begin
    cs_ext = NUMW'(cur_r.cell_size);
    sx     = num_x_r + cs_ext;
    sy     = num_y_r + cs_ext;
    ge_x   = (rem_x_r >= dv_r);
    ge_y   = (rem_y_r >= dv_r);
    raised = {1'b0, rdata_r} + {1'b0, ogr_pkg::HIT_STEP};
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    clr_cnt_nxt   = clr_cnt_r;
    half_nxt      = half_r;
    gcs_nxt       = gcs_r;
    r_nxt         = r_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    hit_ph_nxt    = hit_ph_r;
    num_x_nxt     = num_x_r;
    num_y_nxt     = num_y_r;
    rem_x_nxt     = rem_x_r;
    rem_y_nxt     = rem_y_r;
    dv_nxt        = dv_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    inx_nxt       = inx_r;
    iny_nxt       = iny_r;
    bit_nxt       = bit_r;
    touched_nxt   = touched_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    out_lvl_nxt   = out_lvl_r;
    out_occ_nxt   = out_occ_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    rd_addr       = {qx_r, qy_r};
    wr_addr       = {qx_r, qy_r};
    wr_data       = '0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ogr_pkg::B_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (&clr_cnt_r) state_nxt = ogr_pkg::B_IDLE;
      end
      ogr_pkg::B_IDLE: begin
        if (!q_stat.empty && !out_valid_r) begin
          q_pop       = 1'b1;
          cur_nxt     = q_data;
          half_nxt    = NUMW'(q_data.cell_size) * NUMW'(GRID_SIDE / 2);
          gcs_nxt     = NUMW'(q_data.cell_size) * NUMW'(GRID_SIDE);
          r_nxt       = '0;
          acc_x_nxt   = '0;
          acc_y_nxt   = '0;
          hit_ph_nxt  = 1'b0;
          touched_nxt = '0;
          if (q_data.mode == ogr_pkg::MODE_READ) begin
            rd_en     = 1'b1;
            rd_addr   = {QB'(q_data.cell_row), QB'(q_data.cell_col)};
            rd_ok_nxt = (32'(q_data.cell_row) < GRID_SIDE) &&
                        (32'(q_data.cell_col) < GRID_SIDE);
            state_nxt = ogr_pkg::B_RD_WAIT;
          end else begin
            state_nxt = ogr_pkg::B_SAMPLE;
          end
        end
      end
      ogr_pkg::B_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_cnt_nxt   = '0;
        out_lvl_nxt   = rd_ok_r ? rdata_r : '0;
        out_occ_nxt   = rd_ok_r && (rdata_r > ogr_pkg::OCC_LIMIT);
        state_nxt     = ogr_pkg::B_IDLE;
      end
      ogr_pkg::B_SAMPLE: begin
        if (r_r >= R_W'(cur_r.limit)) begin
          if (cur_r.hit) begin
            hit_ph_nxt = 1'b1;
            num_x_nxt  = NUMW'($signed(cur_r.pos_x)) + NUMW'($signed(cur_r.hoff_x)) + half_r;
            num_y_nxt  = NUMW'($signed(cur_r.pos_y)) + NUMW'($signed(cur_r.hoff_y)) + half_r;
            state_nxt  = ogr_pkg::B_CHECK;
          end else begin
            state_nxt = ogr_pkg::B_DONE;
          end
        end else begin
          num_x_nxt = NUMW'($signed(cur_r.pos_x)) + NUMW'($signed(acc_x_r) >>> 15) + half_r;
          num_y_nxt = NUMW'($signed(cur_r.pos_y)) + NUMW'($signed(acc_y_r) >>> 15) + half_r;
          state_nxt = ogr_pkg::B_CHECK;
        end
      end
      ogr_pkg::B_CHECK: begin
        // a negative numerator only lands in the grid when it truncates to zero
        if (num_x_r[NUMW-1]) begin
          inx_nxt   = !sx[NUMW-1] && (sx != '0);
          rem_x_nxt = '0;
        end else begin
          inx_nxt   = (num_x_r < gcs_r);
          rem_x_nxt = num_x_r;
        end
        if (num_y_r[NUMW-1]) begin
          iny_nxt   = !sy[NUMW-1] && (sy != '0);
          rem_y_nxt = '0;
        end else begin
          iny_nxt   = (num_y_r < gcs_r);
          rem_y_nxt = num_y_r;
        end
        dv_nxt    = cs_ext << (QB - 1);
        bit_nxt   = CW'(QB - 1);
        qx_nxt    = '0;
        qy_nxt    = '0;
        state_nxt = ogr_pkg::B_DIV;
      end
      ogr_pkg::B_DIV: begin
        if (ge_x) rem_x_nxt = rem_x_r - dv_r;
        if (ge_y) rem_y_nxt = rem_y_r - dv_r;
        qx_nxt  = {qx_r[QB-2:0], ge_x};
        qy_nxt  = {qy_r[QB-2:0], ge_y};
        dv_nxt  = dv_r >> 1;
        bit_nxt = bit_r - CW'(1);
        if (bit_r == '0) begin
          state_nxt = (inx_r && iny_r) ? ogr_pkg::B_RMW_RD : ogr_pkg::B_NEXT;
        end
      end
      ogr_pkg::B_RMW_RD: begin
        rd_en     = 1'b1;
        state_nxt = ogr_pkg::B_RMW_WR;
      end
      ogr_pkg::B_RMW_WR: begin
        wr_en = 1'b1;
        if (hit_ph_r) begin
          wr_data = (raised > {1'b0, ogr_pkg::LEVEL_MAX}) ? ogr_pkg::LEVEL_MAX
                                                          : raised[ogr_pkg::LVL_W-1:0];
        end else begin
          wr_data = (rdata_r == '0) ? '0 : rdata_r - ogr_pkg::LVL_W'(1);
        end
        if (touched_r != '1) touched_nxt = touched_r + ogr_pkg::CNT_W'(1);
        state_nxt = ogr_pkg::B_NEXT;
      end
      ogr_pkg::B_NEXT: begin
        if (hit_ph_r) begin
          state_nxt = ogr_pkg::B_DONE;
        end else begin
          r_nxt     = r_r + R_W'(cur_r.cell_size);
          acc_x_nxt = acc_x_r + ACC_W'($signed(cur_r.step_x));
          acc_y_nxt = acc_y_r + ACC_W'($signed(cur_r.step_y));
          state_nxt = ogr_pkg::B_SAMPLE;
        end
      end
      ogr_pkg::B_DONE: begin
        out_valid_nxt = 1'b1;
        out_cnt_nxt   = touched_r;
        out_lvl_nxt   = '0;
        out_occ_nxt   = 1'b0;
        state_nxt     = ogr_pkg::B_IDLE;
      end
      default: state_nxt = ogr_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ogr_pkg::B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      hit_ph_r    <= 1'b0;
      bit_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hit_ph_r    <= hit_ph_nxt;
      bit_r       <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    half_r    <= half_nxt;
    gcs_r     <= gcs_nxt;
    r_r       <= r_nxt;
    acc_x_r   <= acc_x_nxt;
    acc_y_r   <= acc_y_nxt;
    num_x_r   <= num_x_nxt;
    num_y_r   <= num_y_nxt;
    rem_x_r   <= rem_x_nxt;
    rem_y_r   <= rem_y_nxt;
    dv_r      <= dv_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    inx_r     <= inx_nxt;
    iny_r     <= iny_nxt;
    touched_r <= touched_nxt;
    rd_ok_r   <= rd_ok_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_lvl_r <= out_lvl_nxt;
    out_occ_r <= out_occ_nxt;
  end

endmodule

### tb/occupancy_grid_ray_update_test.sv
// occupancy_grid_ray_update_test: self-checking bench for the ray-cast occupancy grid
// depends on ogr_pkg and occupancy_grid_ray_update; holds its own grid copy to predict results
module occupancy_grid_ray_update_test;

  localparam int SIDE = 128;
  localparam int STALL_LIMIT = 200000;
  localparam logic [ogr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;

  typedef struct {
    logic                       mode;
    logic [ogr_pkg::POS_W-1:0]  pos_x;
    logic [ogr_pkg::POS_W-1:0]  pos_y;
    logic [ogr_pkg::ANG_W-1:0]  heading;
    logic [ogr_pkg::ANG_W-1:0]  bearing;
    logic [ogr_pkg::DIST_W-1:0] range_reading;
    logic [ogr_pkg::IDX_W-1:0]  cell_row;
    logic [ogr_pkg::IDX_W-1:0]  cell_col;
  } ray_item_t;

  typedef struct {
    logic [ogr_pkg::CNT_W-1:0] cells_touched;
    logic [ogr_pkg::LVL_W-1:0] cell_level;
    logic                      occupied;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_mode;
  logic [ogr_pkg::POS_W-1:0] in_pos_x, in_pos_y;
  logic [ogr_pkg::ANG_W-1:0] in_heading, in_bearing;
  logic [ogr_pkg::DIST_W-1:0] in_range_reading;
  logic [ogr_pkg::IDX_W-1:0] in_cell_row, in_cell_col;
  logic out_valid, out_stall;
  logic [ogr_pkg::CNT_W-1:0] out_cells_touched;
  logic [ogr_pkg::LVL_W-1:0] out_cell_level;
  logic out_occupied;
  logic cfg_valid, cfg_ready;
  logic [ogr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ogr_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [ogr_pkg::LVL_W-1:0] grid_levels [0:SIDE*SIDE-1];
  logic [ogr_pkg::CS_W-1:0] cur_cell_size;
  logic [ogr_pkg::RANGE_W-1:0] cur_range;
  grid_result_t pending_results [$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  logic [ogr_pkg::IDX_W-1:0] last_hit_row = '0, last_hit_col = '0;

  occupancy_grid_ray_update #(.GRID_SIDE(SIDE)) DUT (.*);

  always #5 clk = ~clk;

  function automatic longint quarter_wave(longint x);
    longint t, u, inner, mid, p, s;
    t = x << 1;
    u = (t * t) >> 15;
    inner = (2320 * u) >> 15;
    mid = ((21024 - inner) * u) >> 15;
    p = 51472 - mid;
    s = (p * t) >> 15;
    if (s > 32767) s = 32767;
    return s;
  endfunction

  function automatic longint angle_sin(logic [ogr_pkg::ANG_W-1:0] a);
    longint v;
    v = a[14] ? quarter_wave(16384 - longint'(a[13:0])) : quarter_wave(longint'(a[13:0]));
    return a[15] ? -v : v;
  endfunction

  function automatic bit grid_slot(longint x, longint y, longint cs, output int slot);
    longint half, ix, iy;
    half = (SIDE / 2) * cs;
    ix = (x + half) / cs;
    iy = (y + half) / cs;
    slot = 0;
    if (ix < 0 || ix >= SIDE || iy < 0 || iy >= SIDE) return 1'b0;
    slot = int'(ix * SIDE + iy);
    return 1'b1;
  endfunction

  // updates the grid copy and queues what the block should answer
  task automatic predict_ray(input ray_item_t it);
    grid_result_t res;
    longint cs, px, py, cv, sv, lim, r, reach;
    logic [ogr_pkg::ANG_W-1:0] ang;
    bit hit;
    int slot, touched, lv;
    res = '{default: '0};
    if (it.mode == ogr_pkg::MODE_READ) begin
      res.cell_level = grid_levels[int'(it.cell_row) * SIDE + int'(it.cell_col)];
      res.occupied = res.cell_level > ogr_pkg::OCC_LIMIT;
    end else begin
      cs = (cur_cell_size == 0) ? 1 : longint'(cur_cell_size);
      px = longint'($signed(it.pos_x));
      py = longint'($signed(it.pos_y));
      ang = it.heading + it.bearing;
      cv = angle_sin(ang + 16'd16384);
      sv = angle_sin(ang);
      reach = longint'(it.range_reading);
      hit = !(reach == 0 || reach > longint'(cur_range));
      lim = hit ? reach : longint'(cur_range);
      touched = 0;
      for (r = 0; r < lim; r += cs) begin
        if (grid_slot(px + ((r * cv) >>> 15), py + ((r * sv) >>> 15), cs, slot)) begin
          if (grid_levels[slot] > 0) grid_levels[slot] = grid_levels[slot] - 1;
          touched++;
        end
      end
      if (hit && grid_slot(px + ((reach * cv) >>> 15), py + ((reach * sv) >>> 15), cs,
                           slot)) begin
        lv = int'(grid_levels[slot]) + int'(ogr_pkg::HIT_STEP);
        grid_levels[slot] = (lv > int'(ogr_pkg::LEVEL_MAX)) ? ogr_pkg::LEVEL_MAX
                                                            : ogr_pkg::LVL_W'(lv);
        touched++;
        last_hit_row = ogr_pkg::IDX_W'(slot / SIDE);
        last_hit_col = ogr_pkg::IDX_W'(slot % SIDE);
      end
      res.cells_touched = (touched > 65535) ? 16'hFFFF : ogr_pkg::CNT_W'(touched);
    end
    pending_results.push_back(res);
  endtask

  task automatic send_item(input ray_item_t it);
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_pos_x <= it.pos_x;
    in_pos_y <= it.pos_y;
    in_heading <= it.heading;
    in_bearing <= it.bearing;
    in_range_reading <= it.range_reading;
    in_cell_row <= it.cell_row;
    in_cell_col <= it.cell_col;
    do @(posedge clk); while (in_stall);
    predict_ray(it);
    if (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [ogr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ogr_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ogr_pkg::CFG_CELL_SIZE) cur_cell_size = val[ogr_pkg::CS_W-1:0];
    else if (idx == ogr_pkg::CFG_SENSOR_RANGE) cur_range = val[ogr_pkg::RANGE_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender holds off until every result is back, then the block gets time to settle
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_grid(input logic [ogr_pkg::CFG_DATA_W-1:0] cs,
                          input logic [ogr_pkg::CFG_DATA_W-1:0] rng);
    drain();
    write_reg(ogr_pkg::CFG_CELL_SIZE, cs);
    write_reg(ogr_pkg::CFG_SENSOR_RANGE, rng);
  endtask

  function automatic ray_item_t random_item();
    ray_item_t it;
    longint cs, span;
    int pick;
    it.mode = ($urandom_range(0, 3) == 0) ? ogr_pkg::MODE_READ : ogr_pkg::MODE_SCAN;
    it.heading = ogr_pkg::ANG_W'($urandom);
    it.bearing = ogr_pkg::ANG_W'($urandom);
    cs = (cur_cell_size == 0) ? 1 : longint'(cur_cell_size);
    span = (SIDE / 2) * cs;
    if ($urandom_range(0, 9) == 0) begin
      it.pos_x = $urandom;
      it.pos_y = $urandom;
    end else begin
      it.pos_x = ogr_pkg::POS_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
      it.pos_y = ogr_pkg::POS_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0: it.range_reading = '0;
      1: it.range_reading = $urandom;
      2: it.range_reading = ogr_pkg::DIST_W'(cur_range) + $urandom_range(1, 1000);
      default: it.range_reading = $urandom_range(1, 32'(cur_range));
    endcase
    if (it.mode == ogr_pkg::MODE_READ && $urandom_range(0, 1) == 0) begin
      it.cell_row = last_hit_row;
      it.cell_col = last_hit_col;
    end else begin
      it.cell_row = ogr_pkg::IDX_W'($urandom);
      it.cell_col = ogr_pkg::IDX_W'($urandom);
    end
    return it;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_item(random_item());
  endtask

  task automatic test_directed;
    ray_item_t it;
    it = '{mode: ogr_pkg::MODE_SCAN, pos_x: '0, pos_y: '0, heading: '0, bearing: '0,
           range_reading: '0, cell_row: '0, cell_col: '0};
    send_item(it);
    it.range_reading = 32'd100000;
    send_item(it);
    send_item(it);
    it.mode = ogr_pkg::MODE_READ;
    it.cell_row = last_hit_row;
    it.cell_col = last_hit_col;
    send_item(it);
    it.mode = ogr_pkg::MODE_SCAN;
    it.heading = 16'hFFFF;
    it.bearing = 16'h0001;
    it.range_reading = ogr_pkg::DIST_W'(cur_range);
    send_item(it);
    it.bearing = 16'hFFFF;
    it.range_reading = ogr_pkg::DIST_W'(cur_range) + 1;
    send_item(it);
    it.heading = 16'h4000;
    it.bearing = 16'h4000;
    it.range_reading = 32'hFFFFFFFF;
    send_item(it);
    it.pos_x = 32'h7FFFFFFF;
    it.pos_y = 32'h80000000;
    it.range_reading = 32'd50000;
    send_item(it);
    it.pos_x = 32'h80000000;
    it.pos_y = 32'h7FFFFFFF;
    it.heading = 16'hC000;
    send_item(it);
    it.pos_x = 32'hFFFF0000;
    it.pos_y = 32'h00010000;
    it.heading = 16'h2000;
    it.bearing = 16'h8000;
    it.range_reading = 32'd1;
    send_item(it);
    it.mode = ogr_pkg::MODE_READ;
    it.cell_row = '0;
    it.cell_col = '1;
    send_item(it);
    it.cell_row = '1;
    it.cell_col = '0;
    send_item(it);
    it.cell_row = '1;
    it.cell_col = '1;
    send_item(it);
    it.cell_row = last_hit_row;
    it.cell_col = last_hit_col;
    send_item(it);
  endtask

  task automatic test_default_grid;
    run_random(300);
  endtask

  task automatic test_fine_grid;
    set_grid(32'hFFE00001, 32'd64);
    run_random(200);
  endtask

  task automatic test_zero_cell_size;
    set_grid(32'd0, 32'd40);
    write_reg(CFG_UNUSED, 32'h12345678);
    run_random(100);
  endtask

  task automatic test_coarse_grid;
    set_grid(32'd1048576, 32'd16777216);
    run_random(150);
  endtask

  task automatic test_mid_grid;
    set_grid(32'd30000, 32'd600000);
    calm = 1'b1;
    run_random(200);
    calm = 1'b0;
    run_random(200);
  endtask

  task automatic test_short_range;
    set_grid(32'd6554, 32'd200000);
    run_random(350);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 18);
  end

  always @(posedge clk) begin
    grid_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_cells_touched !== want.cells_touched) begin
          $error("cells_touched: expected %0d, actual %0d", want.cells_touched, out_cells_touched);
          errors++;
        end
        if (out_cell_level !== want.cell_level) begin
          $error("cell_level: expected %0d, actual %0d", want.cell_level, out_cell_level);
          errors++;
        end
        if (out_occupied !== want.occupied) begin
          $error("occupied: expected %0d, actual %0d", want.occupied, out_occupied);
          errors++;
        end
      end
    end
  end

  // the long clearing sweep after reset stays well under this limit
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = ogr_pkg::MODE_SCAN;
    in_pos_x = '0;
    in_pos_y = '0;
    in_heading = '0;
    in_bearing = '0;
    in_range_reading = '0;
    in_cell_row = '0;
    in_cell_col = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_cell_size = ogr_pkg::CS_RESET;
    cur_range = ogr_pkg::RANGE_RESET;
    foreach (grid_levels[i]) grid_levels[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_default_grid();
    test_fine_grid();
    test_zero_cell_size();
    test_coarse_grid();
    test_mid_grid();
    test_short_range();
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
